// ===== hw/rtl/vector_list_bounding_box_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounding box block
// Immediate-cycle and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef VECTOR_LIST_BOUNDING_BOX_ASSERT_SVH
`define VECTOR_LIST_BOUNDING_BOX_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VLBB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define VLBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/vlbb_pkg.sv =====
// ----------------------------------------------------------------------------
// vlbb_pkg
// Shared constants, command codes and item types for the bounding box block.
// ----------------------------------------------------------------------------
`default_nettype none

package vlbb_pkg;

   // widths
   localparam int COUNT_BITS = 32;
   localparam int COORD_BITS = 32;
   localparam int IN_BITS    = 32;
   localparam int OUT_BITS   = 32;
   localparam int CMD_BITS   = 5;

   typedef logic [CMD_BITS-1:0]          cmd_type;
   typedef logic signed [IN_BITS-1:0]    in_coord_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [OUT_BITS-1:0]   out_coord_type;
   typedef logic [COUNT_BITS-1:0]        count_type;

   // command codes
   localparam cmd_type CMD_LINE_MOVE      = 5'd0;
   localparam cmd_type CMD_LINE_DRAW      = 5'd1;
   localparam cmd_type CMD_POLY_START     = 5'd2;
   localparam cmd_type CMD_POLY_MOVE      = 5'd3;
   localparam cmd_type CMD_POLY_DRAW      = 5'd4;
   localparam cmd_type CMD_POLY_END       = 5'd5;
   localparam cmd_type CMD_POLY_NORMAL    = 5'd6;
   localparam cmd_type CMD_TRI_START      = 5'd7;
   localparam cmd_type CMD_TRI_MOVE       = 5'd8;
   localparam cmd_type CMD_TRI_DRAW       = 5'd9;
   localparam cmd_type CMD_TRI_END        = 5'd10;
   localparam cmd_type CMD_TRI_NORMAL     = 5'd11;
   localparam cmd_type CMD_POINT_DRAW     = 5'd12;
   localparam cmd_type CMD_MODEL_MATRIX   = 5'd13;
   localparam cmd_type CMD_DISPLAY_MATRIX = 5'd14;
   localparam cmd_type CMD_POINT_SIZE     = 5'd15;
   localparam cmd_type CMD_LINE_WIDTH     = 5'd16;
   localparam cmd_type CMD_NONE           = 5'd0;
   localparam cmd_type CMD_FIRST_UNKNOWN  = 5'd17;

   // one input item
   typedef struct packed {
      cmd_type      cmd;
      in_coord_type x_coord;
      in_coord_type y_coord;
      in_coord_type z_coord;
      logic         last;
   } item_type;

   // one result item
   typedef struct packed {
      out_coord_type min_x;
      out_coord_type min_y;
      out_coord_type min_z;
      out_coord_type max_x;
      out_coord_type max_y;
      out_coord_type max_z;
      logic [OUT_BITS-1:0] item_count;
      logic         bad_found;
      cmd_type      bad_cmd;
   } result_type;

   // handshake between the core and the stage registers
   typedef struct packed {
      logic take;      // input register item consumed this cycle
      logic res_load;  // result register loads this cycle
   } core_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/vector_list_bounding_box.sv =====
// A last item moves from the input register through the core into the result register,
// which offers it on the response channel. One item per cycle is taken unless a last item
// waits; the box update is a single compare-and-select pass between the two registers.
// A waiting result does not stop input: items keep entering until a second
// last item meets an occupied result register.
// Reset (synchronous, active high) empties the box and clears both valid flags.
// ----------------------------------------------------------------------------
// vector_list_bounding_box
// 3D axis-aligned bounding box over a stream of drawing command items.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_list_bounding_box (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,  // x_coord[31:0], y_coord[63:32], z_coord[95:64]
   input  wire logic [7:0]   req_tuser,  // cmd[4:0]
   input  wire logic         req_tlast,
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [223:0]      rsp_tdata,  // min_x, min_y, min_z, max_x, max_y, max_z,
                                         // item_count, 32 bits each from bit 0
   output logic [7:0]        rsp_tuser   // bad_found[0], bad_cmd[5:1]
);

   vlbb_pkg::item_type      req_item;
   vlbb_pkg::item_type      item;
   logic                    item_valid;
   vlbb_pkg::core_ctrl_type ctrl;
   vlbb_pkg::result_type    result;
   vlbb_pkg::result_type    rsp_result;
   logic                    out_free;

   // unpack request
   assign req_item = '{cmd:     req_tuser[4:0],
                       x_coord: req_tdata[31:0],
                       y_coord: req_tdata[63:32],
                       z_coord: req_tdata[95:64],
                       last:    req_tlast};

   vlbb_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .ctrl       (ctrl),
      .item_valid (item_valid),
      .item       (item)
   );

   vlbb_box_core u_box_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .ctrl       (ctrl),
      .result     (result)
   );

   vlbb_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   // pack response
   assign rsp_tdata = {rsp_result.item_count,
                       rsp_result.max_z, rsp_result.max_y, rsp_result.max_x,
                       rsp_result.min_z, rsp_result.min_y, rsp_result.min_x};
   assign rsp_tuser = {2'b00, rsp_result.bad_cmd, rsp_result.bad_found};

endmodule

`default_nettype wire

// ===== hw/rtl/vlbb_in_stage.sv =====
// ----------------------------------------------------------------------------
// vlbb_in_stage
// Input register: takes one request item per cycle unless a held item stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module vlbb_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire vlbb_pkg::item_type req_item,
   input  wire vlbb_pkg::core_ctrl_type ctrl,
   output logic                   item_valid,
   output vlbb_pkg::item_type     item
);

   logic               valid_ff, valid_in;
   vlbb_pkg::item_type item_ff;
   logic               load;

   // free when empty or when the held item leaves this cycle
   assign req_tready = !valid_ff || ctrl.take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (ctrl.take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/vlbb_box_core.sv =====
// ----------------------------------------------------------------------------
// vlbb_box_core
// Running box state, command decode, saturating widen and result forming.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector_list_bounding_box_assert.svh"

module vlbb_box_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire vlbb_pkg::item_type item,
   input  wire logic               out_free,
   output vlbb_pkg::core_ctrl_type ctrl,
   output vlbb_pkg::result_type    result
);

   localparam int COORD_BITS = vlbb_pkg::COORD_BITS;
   localparam int COUNT_BITS = vlbb_pkg::COUNT_BITS;
   localparam int OUT_BITS   = vlbb_pkg::OUT_BITS;
   localparam int IN_BITS    = vlbb_pkg::IN_BITS;
   // room for a point plus or minus 1.0 without overflow
   localparam int BASE_BITS  = (COORD_BITS > IN_BITS) ? COORD_BITS : IN_BITS;
   localparam int SUM_BITS   = BASE_BITS + 2;
   localparam int WIDE_BITS  = (COORD_BITS > OUT_BITS) ? COORD_BITS : OUT_BITS;
   localparam int CNTW_BITS  = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

   typedef logic signed [SUM_BITS-1:0]  sum_type;
   typedef logic signed [WIDE_BITS-1:0] wide_type;

   localparam vlbb_pkg::coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam vlbb_pkg::coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam sum_type SUM_COORD_MAX = SUM_BITS'(COORD_MAX);
   localparam sum_type SUM_COORD_MIN = SUM_BITS'(COORD_MIN);
   localparam sum_type ONE_Q16 = sum_type'(65536);
   localparam vlbb_pkg::out_coord_type OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam vlbb_pkg::out_coord_type OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
   localparam wide_type WIDE_OUT_MAX = WIDE_BITS'(OUT_MAX);
   localparam wide_type WIDE_OUT_MIN = WIDE_BITS'(OUT_MIN);
   localparam vlbb_pkg::count_type COUNT_MAX = '1;
   localparam logic [CNTW_BITS-1:0] CNT_OUT_MAX = CNTW_BITS'({OUT_BITS{1'b1}});

   // clamp a padded sum into the coordinate range
   function automatic vlbb_pkg::coord_type clamp_coord(input sum_type v);
      vlbb_pkg::coord_type r;
      if (v < SUM_COORD_MIN) begin
         r = COORD_MIN;
      end else if (v > SUM_COORD_MAX) begin
         r = COORD_MAX;
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   // clamp a box corner into the output range
   function automatic vlbb_pkg::out_coord_type clamp_out(input vlbb_pkg::coord_type c);
      wide_type w;
      vlbb_pkg::out_coord_type r;
      w = WIDE_BITS'(c);
      if (w < WIDE_OUT_MIN) begin
         r = OUT_MIN;
      end else if (w > WIDE_OUT_MAX) begin
         r = OUT_MAX;
      end else begin
         r = w[OUT_BITS-1:0];
      end
      return r;
   endfunction

   vlbb_pkg::coord_type box_min_ff [3];
   vlbb_pkg::coord_type box_max_ff [3];
   vlbb_pkg::coord_type box_min_in [3];
   vlbb_pkg::coord_type box_max_in [3];
   logic                skip_ff, skip_in;
   logic                err_ff, err_in;
   vlbb_pkg::cmd_type   code_ff, code_in;
   vlbb_pkg::count_type count_ff, count_in;

   // item update values before the end-of-list clear
   vlbb_pkg::coord_type upd_min [3];
   vlbb_pkg::coord_type upd_max [3];
   logic                upd_skip, upd_err;
   vlbb_pkg::cmd_type   upd_code;
   vlbb_pkg::count_type upd_count;

   logic take;
   logic res_load;

   // consume the held item; a last item also needs the result register
   assign take     = item_valid && (!item.last || out_free);
   assign res_load = take && item.last;
   assign ctrl     = '{take: take, res_load: res_load};

   // command decode and widen
   always_comb begin
      vlbb_pkg::in_coord_type pt [3];
      logic    grow;
      logic    pad;
      sum_type pe;
      sum_type pad_val;
      vlbb_pkg::coord_type lo;
      vlbb_pkg::coord_type hi;

      pt[0] = item.x_coord;
      pt[1] = item.y_coord;
      pt[2] = item.z_coord;
      grow      = 1'b0;
      pad       = 1'b0;
      upd_skip  = skip_ff;
      upd_err   = err_ff;
      upd_code  = code_ff;
      upd_count = count_ff;

      if (!err_ff) begin
         if (!(skip_ff && (item.cmd != vlbb_pkg::CMD_MODEL_MATRIX))) begin
            upd_skip = 1'b0;
            case (item.cmd) inside
               vlbb_pkg::CMD_LINE_MOVE, vlbb_pkg::CMD_LINE_DRAW,
               vlbb_pkg::CMD_POLY_MOVE, vlbb_pkg::CMD_POLY_DRAW,
               vlbb_pkg::CMD_POLY_END, vlbb_pkg::CMD_TRI_MOVE,
               vlbb_pkg::CMD_TRI_DRAW, vlbb_pkg::CMD_TRI_END: begin
                  grow = 1'b1;
               end
               vlbb_pkg::CMD_POINT_DRAW: begin
                  grow = 1'b1;
                  pad  = 1'b1;
               end
               vlbb_pkg::CMD_DISPLAY_MATRIX: begin
                  grow     = 1'b1;
                  pad      = 1'b1;
                  upd_skip = 1'b1;
               end
               vlbb_pkg::CMD_POLY_START, vlbb_pkg::CMD_POLY_NORMAL,
               vlbb_pkg::CMD_TRI_START, vlbb_pkg::CMD_TRI_NORMAL,
               vlbb_pkg::CMD_MODEL_MATRIX, vlbb_pkg::CMD_POINT_SIZE,
               vlbb_pkg::CMD_LINE_WIDTH: begin
                  grow = 1'b0;
               end
               default: begin
                  upd_err  = 1'b1;
                  upd_code = item.cmd;
               end
            endcase
         end
         // count every item up to, not including, the first unknown one
         if (!upd_err && (count_ff != COUNT_MAX)) begin
            upd_count = count_ff + 1'b1;
         end
      end

      pad_val = pad ? ONE_Q16 : '0;
      for (int k = 0; k < 3; k++) begin
         pe = SUM_BITS'(pt[k]);
         lo = clamp_coord(pe - pad_val);
         hi = clamp_coord(pe + pad_val);
         upd_min[k] = (grow && (lo < box_min_ff[k])) ? lo : box_min_ff[k];
         upd_max[k] = (grow && (hi > box_max_ff[k])) ? hi : box_max_ff[k];
      end
   end

   // next state: hold, update, or clear after the last item
   always_comb begin
      box_min_in = box_min_ff;
      box_max_in = box_max_ff;
      skip_in    = skip_ff;
      err_in     = err_ff;
      code_in    = code_ff;
      count_in   = count_ff;
      if (res_load) begin
         for (int k = 0; k < 3; k++) begin
            box_min_in[k] = COORD_MAX;
            box_max_in[k] = COORD_MIN;
         end
         skip_in  = 1'b0;
         err_in   = 1'b0;
         code_in  = vlbb_pkg::CMD_NONE;
         count_in = '0;
      end else if (take) begin
         box_min_in = upd_min;
         box_max_in = upd_max;
         skip_in    = upd_skip;
         err_in     = upd_err;
         code_in    = upd_code;
         count_in   = upd_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            box_min_ff[k] <= COORD_MAX;
            box_max_ff[k] <= COORD_MIN;
         end
         skip_ff  <= 1'b0;
         err_ff   <= 1'b0;
         code_ff  <= vlbb_pkg::CMD_NONE;
         count_ff <= '0;
      end else begin
         box_min_ff <= box_min_in;
         box_max_ff <= box_max_in;
         skip_ff    <= skip_in;
         err_ff     <= err_in;
         code_ff    <= code_in;
         count_ff   <= count_in;
      end
   end

   // result from the updated state of the last item
   always_comb begin
      logic [CNTW_BITS-1:0] cnt_w;
      cnt_w = CNTW_BITS'(upd_count);
      result.min_x = clamp_out(upd_min[0]);
      result.min_y = clamp_out(upd_min[1]);
      result.min_z = clamp_out(upd_min[2]);
      result.max_x = clamp_out(upd_max[0]);
      result.max_y = clamp_out(upd_max[1]);
      result.max_z = clamp_out(upd_max[2]);
      result.item_count = (cnt_w > CNT_OUT_MAX) ? {OUT_BITS{1'b1}} : cnt_w[OUT_BITS-1:0];
      result.bad_found  = upd_err;
      result.bad_cmd    = upd_code;
   end

   // checks
   `VLBB_ASSERT_NEXT(a_last_clears, clock, reset, res_load,
      (!err_ff && !skip_ff && (count_ff == '0)), "state not cleared after last item")
   `VLBB_ASSERT_NEXT(a_err_freezes_count, clock, reset, (err_ff && !res_load),
      ($stable(count_ff) && $stable(code_ff)), "count or code moved after error")
   `VLBB_ASSERT_NOW(a_err_code_unknown, clock, reset, err_ff,
      (code_ff >= vlbb_pkg::CMD_FIRST_UNKNOWN), "error code is a known command")
   `VLBB_ASSERT_NOW(a_no_err_no_code, clock, reset, !err_ff,
      (code_ff == vlbb_pkg::CMD_NONE), "error code set without error")

endmodule

`default_nettype wire

// ===== hw/rtl/vlbb_out_stage.sv =====
// ----------------------------------------------------------------------------
// vlbb_out_stage
// Result register: holds one result item until the response channel takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module vlbb_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire vlbb_pkg::core_ctrl_type ctrl,
   input  wire vlbb_pkg::result_type result,
   output logic                      out_free,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output vlbb_pkg::result_type      rsp_result
);

   logic                 valid_ff, valid_in;
   vlbb_pkg::result_type result_ff;

   // room for a new result when empty or draining this cycle
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      if (ctrl.res_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (ctrl.res_load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vector_list_bounding_box. A short table of
// command lists (empty box, coordinate extremes, saturation at +/-1.0, skip
// until model matrix, unknown codes) is followed by random command lists.
// A box tracker predicts each result, and every result item is compared
// field by field with the oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     RANDOM_ITEMS = 600;
   localparam longint ONE_Q16      = 65536;
   localparam longint COORD_HI     = (64'sd1 <<< (vlbb_pkg::COORD_BITS - 1)) - 1;
   localparam longint COORD_LO     = -COORD_HI - 1;
   localparam longint OUT_HI       = (64'sd1 <<< (vlbb_pkg::OUT_BITS - 1)) - 1;
   localparam longint OUT_LO       = -OUT_HI - 1;
   localparam vlbb_pkg::cmd_type CMD_TOP_CODE = '1;

   localparam vlbb_pkg::in_coord_type MAXC = 32'sh7FFFFFFF;
   localparam vlbb_pkg::in_coord_type MINC = 32'sh80000000;

   // command groups for random lists
   localparam vlbb_pkg::cmd_type WIDEN_CMDS [8] = '{vlbb_pkg::CMD_LINE_MOVE,
      vlbb_pkg::CMD_LINE_DRAW, vlbb_pkg::CMD_POLY_MOVE, vlbb_pkg::CMD_POLY_DRAW,
      vlbb_pkg::CMD_POLY_END, vlbb_pkg::CMD_TRI_MOVE, vlbb_pkg::CMD_TRI_DRAW,
      vlbb_pkg::CMD_TRI_END};
   localparam vlbb_pkg::cmd_type ATTR_CMDS [6] = '{vlbb_pkg::CMD_POLY_START,
      vlbb_pkg::CMD_POLY_NORMAL, vlbb_pkg::CMD_TRI_START, vlbb_pkg::CMD_TRI_NORMAL,
      vlbb_pkg::CMD_POINT_SIZE, vlbb_pkg::CMD_LINE_WIDTH};

   typedef struct {
      vlbb_pkg::item_type   it;
      bit                   typed;
      vlbb_pkg::result_type want;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;
   logic [7:0]   req_tuser;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [223:0] rsp_tdata;
   logic [7:0]   rsp_tuser;

   // box tracker state
   longint              box_lo [3];
   longint              box_hi [3];
   logic                skip_mode;
   logic                halted;
   vlbb_pkg::cmd_type   halt_code;
   vlbb_pkg::count_type seen_count;

   vlbb_pkg::result_type box_queue [$];
   stim_row_type         dir_rows [$];
   int                   error_count;
   bit                   calm;

   vector_list_bounding_box dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 22);
   endfunction

   function automatic longint clamp_to(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void clear_box();
      for (int k = 0; k < 3; k++) begin
         box_lo[k] = COORD_HI;
         box_hi[k] = COORD_LO;
      end
      skip_mode  = 1'b0;
      halted     = 1'b0;
      halt_code  = vlbb_pkg::CMD_NONE;
      seen_count = '0;
   endfunction

   // advance the tracker by one item; returns 1 when a result is due
   function automatic bit predict_item(input vlbb_pkg::item_type it,
                                       output vlbb_pkg::result_type r);
      longint p [3];
      longint pad;
      longint lo;
      longint hi;
      bit     grow;
      p[0] = longint'(it.x_coord);
      p[1] = longint'(it.y_coord);
      p[2] = longint'(it.z_coord);
      grow = 1'b0;
      pad  = 0;
      r    = '0;
      if (!halted) begin
         if (!(skip_mode && it.cmd != vlbb_pkg::CMD_MODEL_MATRIX)) begin
            skip_mode = 1'b0;
            case (it.cmd)
               vlbb_pkg::CMD_POLY_START, vlbb_pkg::CMD_POLY_NORMAL,
               vlbb_pkg::CMD_TRI_START, vlbb_pkg::CMD_TRI_NORMAL,
               vlbb_pkg::CMD_MODEL_MATRIX, vlbb_pkg::CMD_POINT_SIZE,
               vlbb_pkg::CMD_LINE_WIDTH: ;
               vlbb_pkg::CMD_LINE_MOVE, vlbb_pkg::CMD_LINE_DRAW,
               vlbb_pkg::CMD_POLY_MOVE, vlbb_pkg::CMD_POLY_DRAW,
               vlbb_pkg::CMD_POLY_END, vlbb_pkg::CMD_TRI_MOVE,
               vlbb_pkg::CMD_TRI_DRAW, vlbb_pkg::CMD_TRI_END: begin
                  grow = 1'b1;
               end
               vlbb_pkg::CMD_DISPLAY_MATRIX: begin
                  skip_mode = 1'b1;
                  grow      = 1'b1;
                  pad       = ONE_Q16;
               end
               vlbb_pkg::CMD_POINT_DRAW: begin
                  grow = 1'b1;
                  pad  = ONE_Q16;
               end
               default: begin
                  halted    = 1'b1;
                  halt_code = it.cmd;
               end
            endcase
            if (grow) begin
               for (int k = 0; k < 3; k++) begin
                  lo = clamp_to(p[k] - pad, COORD_LO, COORD_HI);
                  hi = clamp_to(p[k] + pad, COORD_LO, COORD_HI);
                  if (lo < box_lo[k]) box_lo[k] = lo;
                  if (hi > box_hi[k]) box_hi[k] = hi;
               end
            end
         end
         if (!halted && seen_count != '1) seen_count++;
      end
      if (!it.last) return 1'b0;
      r.min_x      = vlbb_pkg::out_coord_type'(clamp_to(box_lo[0], OUT_LO, OUT_HI));
      r.min_y      = vlbb_pkg::out_coord_type'(clamp_to(box_lo[1], OUT_LO, OUT_HI));
      r.min_z      = vlbb_pkg::out_coord_type'(clamp_to(box_lo[2], OUT_LO, OUT_HI));
      r.max_x      = vlbb_pkg::out_coord_type'(clamp_to(box_hi[0], OUT_LO, OUT_HI));
      r.max_y      = vlbb_pkg::out_coord_type'(clamp_to(box_hi[1], OUT_LO, OUT_HI));
      r.max_z      = vlbb_pkg::out_coord_type'(clamp_to(box_hi[2], OUT_LO, OUT_HI));
      r.item_count = seen_count;
      r.bad_found  = halted;
      r.bad_cmd    = halt_code;
      clear_box();
      return 1'b1;
   endfunction

   function automatic vlbb_pkg::result_type box_of(
         vlbb_pkg::out_coord_type mnx, vlbb_pkg::out_coord_type mny,
         vlbb_pkg::out_coord_type mnz, vlbb_pkg::out_coord_type mxx,
         vlbb_pkg::out_coord_type mxy, vlbb_pkg::out_coord_type mxz,
         logic [31:0] count, logic bad, vlbb_pkg::cmd_type code);
      vlbb_pkg::result_type r;
      r.min_x      = mnx;
      r.min_y      = mny;
      r.min_z      = mnz;
      r.max_x      = mxx;
      r.max_y      = mxy;
      r.max_z      = mxz;
      r.item_count = count;
      r.bad_found  = bad;
      r.bad_cmd    = code;
      return r;
   endfunction

   task automatic add_row(input vlbb_pkg::cmd_type c, input vlbb_pkg::in_coord_type x,
                          input vlbb_pkg::in_coord_type y,
                          input vlbb_pkg::in_coord_type z, input bit l,
                          input bit typed = 1'b0,
                          input vlbb_pkg::result_type w = '0);
      stim_row_type row;
      row.it.cmd     = c;
      row.it.x_coord = x;
      row.it.y_coord = y;
      row.it.z_coord = z;
      row.it.last    = l;
      row.typed      = typed;
      row.want       = w;
      dir_rows.push_back(row);
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // drive one item at the falling edge, hold until taken
   task automatic send_item(input vlbb_pkg::item_type it, input bit typed,
                            input vlbb_pkg::result_type want);
      vlbb_pkg::result_type r;
      bit                   due;
      while (idle_now()) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {it.z_coord, it.y_coord, it.x_coord};
      req_tuser  = {3'd0, it.cmd};
      req_tlast  = it.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      due = predict_item(it, r);
      if (due) box_queue.push_back(typed ? want : r);
      @(negedge clock);
   endtask

   task automatic drain_boxes();
      req_tvalid = 1'b0;
      while (box_queue.size() != 0) @(negedge clock);
   endtask

   function automatic vlbb_pkg::in_coord_type rand_coord();
      case ($urandom_range(9))
         0:       return MAXC - vlbb_pkg::in_coord_type'($urandom_range(131072));
         1:       return MINC + vlbb_pkg::in_coord_type'($urandom_range(131072));
         2, 3, 4: return vlbb_pkg::in_coord_type'($urandom);
         default: return vlbb_pkg::in_coord_type'($urandom_range(1 << 20)) - (1 << 19);
      endcase
   endfunction

   function automatic vlbb_pkg::cmd_type rand_cmd();
      int r;
      r = $urandom_range(99);
      if (r < 4)  return vlbb_pkg::CMD_FIRST_UNKNOWN +
                         vlbb_pkg::cmd_type'($urandom_range(CMD_TOP_CODE -
                                                            vlbb_pkg::CMD_FIRST_UNKNOWN));
      if (r < 10) return vlbb_pkg::CMD_DISPLAY_MATRIX;
      if (r < 18) return vlbb_pkg::CMD_MODEL_MATRIX;
      if (r < 26) return vlbb_pkg::CMD_POINT_DRAW;
      if (r < 40) return ATTR_CMDS[$urandom_range(5)];
      return WIDEN_CMDS[$urandom_range(7)];
   endfunction

   // result side: random back-pressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = !idle_now();
      end
   end

   // compare each taken result with the oldest prediction
   always @(posedge clock) begin : watch_results
      vlbb_pkg::result_type got;
      vlbb_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.min_x      = rsp_tdata[31:0];
         got.min_y      = rsp_tdata[63:32];
         got.min_z      = rsp_tdata[95:64];
         got.max_x      = rsp_tdata[127:96];
         got.max_y      = rsp_tdata[159:128];
         got.max_z      = rsp_tdata[191:160];
         got.item_count = rsp_tdata[223:192];
         got.bad_found  = rsp_tuser[0];
         got.bad_cmd    = rsp_tuser[5:1];
         if (box_queue.size() == 0) begin
            report_mismatch("result item with no box pending");
         end else begin
            want = box_queue.pop_front();
            check_field("min_x", got.min_x, want.min_x);
            check_field("min_y", got.min_y, want.min_y);
            check_field("min_z", got.min_z, want.min_z);
            check_field("max_x", got.max_x, want.max_x);
            check_field("max_y", got.max_y, want.max_y);
            check_field("max_z", got.max_z, want.max_z);
            check_field("item_count", got.item_count, want.item_count);
            check_field("bad_found", got.bad_found, want.bad_found);
            check_field("bad_cmd", got.bad_cmd, want.bad_cmd);
         end
      end
   end

   // stimulus
   initial begin
      vlbb_pkg::item_type it;
      int                 sent;
      int                 list_len;
      bit                 drained;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      req_tlast   = 1'b0;
      calm        = 1'b0;
      error_count = 0;
      drained     = 1'b0;
      sent        = 0;
      clear_box();

      // empty box
      add_row(vlbb_pkg::CMD_POINT_SIZE, 32'sh00001234, -5, 77, 1'b1, 1'b1,
              box_of(MAXC, MAXC, MAXC, MINC, MINC, MINC, 1, 1'b0, vlbb_pkg::CMD_NONE));
      // both coordinate extremes
      add_row(vlbb_pkg::CMD_LINE_MOVE, MAXC, MAXC, MAXC, 1'b0);
      add_row(vlbb_pkg::CMD_LINE_DRAW, MINC, MINC, MINC, 1'b1, 1'b1,
              box_of(MINC, MINC, MINC, MAXC, MAXC, MAXC, 2, 1'b0, vlbb_pkg::CMD_NONE));
      // point pad saturates on the high side
      add_row(vlbb_pkg::CMD_POINT_DRAW, MAXC, MAXC, MAXC, 1'b1, 1'b1,
              box_of(32'sh7FFEFFFF, 32'sh7FFEFFFF, 32'sh7FFEFFFF, MAXC, MAXC, MAXC,
                     1, 1'b0, vlbb_pkg::CMD_NONE));
      // display pad saturates low, unknown skipped, model resumes, then an error
      add_row(vlbb_pkg::CMD_DISPLAY_MATRIX, MINC, MINC, MINC, 1'b0);
      add_row(vlbb_pkg::CMD_FIRST_UNKNOWN + 5'd3, 32'sh00500000, 0, 0, 1'b0);
      add_row(vlbb_pkg::CMD_MODEL_MATRIX, 0, 0, 0, 1'b0);
      add_row(CMD_TOP_CODE, 0, 0, 0, 1'b0);
      add_row(vlbb_pkg::CMD_LINE_MOVE, MAXC, MAXC, MAXC, 1'b0);
      add_row(vlbb_pkg::CMD_LINE_DRAW, 0, 0, 0, 1'b1, 1'b1,
              box_of(MINC, MINC, MINC, 32'sh80010000, 32'sh80010000, 32'sh80010000,
                     3, 1'b1, CMD_TOP_CODE));
      // unknown as the only item
      add_row(vlbb_pkg::CMD_FIRST_UNKNOWN, 1, 2, 3, 1'b1, 1'b1,
              box_of(MAXC, MAXC, MAXC, MINC, MINC, MINC, 0, 1'b1,
                     vlbb_pkg::CMD_FIRST_UNKNOWN));
      // one list through the remaining commands
      add_row(vlbb_pkg::CMD_POLY_START, 32'sh00010000, 32'sh00020000, 32'sh00030000, 1'b0);
      add_row(vlbb_pkg::CMD_POLY_MOVE, 32'shFFFB0000, 32'sh00120000, 32'sh7FFF0000, 1'b0);
      add_row(vlbb_pkg::CMD_POLY_DRAW, 32'sh00008000, 32'shFFFF8000, 32'sh00000001, 1'b0);
      add_row(vlbb_pkg::CMD_POLY_END, 32'sh12345678, 32'shEDCBA988, 32'sh00000000, 1'b0);
      add_row(vlbb_pkg::CMD_POLY_NORMAL, MAXC, MINC, MAXC, 1'b0);
      add_row(vlbb_pkg::CMD_TRI_START, MINC, MAXC, MINC, 1'b0);
      add_row(vlbb_pkg::CMD_TRI_MOVE, 32'sh40000000, 32'shC0000000, 32'sh00000100, 1'b0);
      add_row(vlbb_pkg::CMD_TRI_DRAW, 32'shFFFFFFFF, 32'sh00000001, 32'shAAAA5555, 1'b0);
      add_row(vlbb_pkg::CMD_TRI_END, 32'sh5555AAAA, 32'sh7FFFFFFE, 32'sh80000001, 1'b0);
      add_row(vlbb_pkg::CMD_TRI_NORMAL, 32'sh00000000, 32'sh00000000, 32'sh00000000, 1'b0);
      add_row(vlbb_pkg::CMD_LINE_WIDTH, 32'sh00640000, 32'sh00000000, 32'shFF9C0000, 1'b1);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
      drain_boxes();

      // random command lists, mostly short, a few long
      while (sent < RANDOM_ITEMS) begin
         if (!drained && sent >= 150) begin
            drain_boxes();
            drained = 1'b1;
         end
         list_len = ($urandom_range(99) < 10) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         for (int j = 0; j < list_len; j++) begin
            calm       = (sent >= 300 && sent < 420);
            it.cmd     = rand_cmd();
            it.x_coord = rand_coord();
            it.y_coord = rand_coord();
            it.z_coord = rand_coord();
            it.last    = (j == list_len - 1);
            sent++;
            send_item(it, 1'b0, '0);
         end
      end
      calm = 1'b0;
      req_tvalid = 1'b0;

      while (box_queue.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (box_queue.size() != 0)
         report_mismatch($sformatf("%0d boxes never arrived", box_queue.size()));

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== vector_list_bounding_box.f =====
+incdir+hw/rtl
hw/rtl/vlbb_pkg.sv
hw/rtl/vlbb_in_stage.sv
hw/rtl/vlbb_box_core.sv
hw/rtl/vlbb_out_stage.sv
hw/rtl/vector_list_bounding_box.sv
verif/tb.sv
